/* design/vqbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vqbd_pkg
// Shared constants, register indexes and tile shape helpers for the
// vector-quantization block decoder.
// ----------------------------------------------------------------------------
package vqbd_pkg;

  localparam int CB_BYTES = 4096;
  localparam int CB_AW    = $clog2(CB_BYTES);

  localparam int RA_W     = 12;   // pointer * entry size + pixel index
  localparam int PADDR_W  = 24;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 11;
  localparam int BW_W     = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IW   = 2;
  localparam int MAX_CNT  = 1024;

  typedef enum logic [CFG_IW-1:0] {
    CFG_BLOCK_SHAPE    = 2'd0,
    CFG_BLOCKS_PER_ROW = 2'd1,
    CFG_NUM_ROWS       = 2'd2,
    CFG_BUFFER_WIDTH   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    SHAPE_2X2 = 2'd0,
    SHAPE_2X3 = 2'd1,
    SHAPE_4X2 = 2'd2,
    SHAPE_4X4 = 2'd3
  } shape_t;

  // tile width minus one
  function automatic logic [1:0] tile_wm1(input logic [1:0] shape);
    logic [1:0] r;
    begin
      r = shape[1] ? 2'd3 : 2'd1;
      return r;
    end
  endfunction

  // tile height
  function automatic logic [2:0] tile_h(input logic [1:0] shape);
    logic [2:0] r;
    begin
      case (shape_t'(shape))
        SHAPE_2X2: r = 3'd2;
        SHAPE_2X3: r = 3'd3;
        SHAPE_4X2: r = 3'd2;
        SHAPE_4X4: r = 3'd4;
        default:   r = 3'd2;
      endcase
      return r;
    end
  endfunction

  // entry size minus one
  function automatic logic [3:0] tile_szm1(input logic [1:0] shape);
    logic [3:0] r;
    begin
      case (shape_t'(shape))
        SHAPE_2X2: r = 4'd3;
        SHAPE_2X3: r = 4'd5;
        SHAPE_4X2: r = 4'd7;
        SHAPE_4X4: r = 4'd15;
        default:   r = 4'd3;
      endcase
      return r;
    end
  endfunction

  // clamp a tile count to 1..1024
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    begin
      if (v == '0) r = CNT_W'(1);
      else if (v > CNT_W'(MAX_CNT)) r = CNT_W'(MAX_CNT);
      else r = v;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* design/vq_block_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vq_block_decoder
// Loads codebook bytes into a byte store and expands block pointers into
// tiles of pixels, each tagged with its frame-buffer address.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pointer loads the generator registers; each store
//   read then lands in the output stage, which drives pixel_valid.
// Throughput: one pixel per cycle from the single store read port unless
//   pixel_stall holds the output; a tile holds 4, 6, 8 or 16 pixels and the
//   next pointer is taken on the cycle the last pixel read issues.
// Reset: clears position and registers to defaults; the codebook store is
//   not cleared and reads as undefined until written.
module vq_block_decoder
  import vqbd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               cfg_write,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,

  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               mode,
  input  wire logic [11:0]        codebook_address,
  input  wire logic [7:0]         codebook_byte,
  input  wire logic [7:0]         block_pointer,

  output logic                    pixel_valid,
  input  wire logic               pixel_stall,
  output logic [PADDR_W-1:0]      pixel_address,
  output logic [7:0]              pixel_value,
  output logic                    last_of_tile,
  output logic                    last_of_frame
);

  // configuration
  logic [1:0]        block_shape;
  logic [CNT_W-1:0]  blocks_per_row;
  logic [CNT_W-1:0]  num_rows;
  logic [BW_W-1:0]   buffer_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_shape    <= 2'd2;
      blocks_per_row <= CNT_W'(80);
      num_rows       <= CNT_W'(100);
      buffer_width   <= BW_W'(320);
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_BLOCK_SHAPE:    block_shape    <= cfg_data[1:0];
        CFG_BLOCKS_PER_ROW: blocks_per_row <= cfg_data[CNT_W-1:0];
        CFG_NUM_ROWS:       num_rows       <= cfg_data[CNT_W-1:0];
        CFG_BUFFER_WIDTH:   buffer_width   <= cfg_data[BW_W-1:0];
        default: ;
      endcase
    end
  end

  // tile position
  logic [POS_W-1:0] tile_column;
  logic [POS_W-1:0] tile_row;

  // pixel generator
  logic              busy;
  logic [RA_W-1:0]   gen_base;
  logic [3:0]        gen_n;
  logic [1:0]        gen_x;
  logic [1:0]        gen_wm1;
  logic [3:0]        gen_szm1;
  logic [PADDR_W-1:0] gen_line;
  logic [11:0]       gen_col;
  logic [BW_W-1:0]   gen_bw;
  logic              gen_end_frame;

  // output stage, aligned with the store read data
  logic               s1_valid;
  logic [PADDR_W-1:0] s1_addr;
  logic               s1_oob;
  logic               s1_last_tile;
  logic               s1_last_frame;
  logic [7:0]         rd_data;

  logic [7:0] store [CB_BYTES];

  logic advance, gen_last, gen_free, accept, dec_accept, wr_accept, issue;

  assign advance    = !s1_valid || !pixel_stall;
  assign gen_last   = (gen_n == gen_szm1);
  assign issue      = busy && advance;
  assign gen_free   = !busy || (advance && gen_last);
  assign item_stall = !gen_free;
  assign accept     = item_valid && gen_free;
  assign dec_accept = accept && mode;
  assign wr_accept  = accept && !mode;

  // per-tile setup
  logic [CNT_W-1:0] bpr_c, nr_c;
  logic             end_row, last_row, end_frame;
  logic [2:0]       h_cur;
  logic [11:0]      row_h;
  logic [RA_W-1:0]  base_cur;
  logic [11:0]      col_cur;

  always_comb begin
    bpr_c     = clamp_cnt(blocks_per_row);
    nr_c      = clamp_cnt(num_rows);
    end_row   = CNT_W'(tile_column) >= (bpr_c - CNT_W'(1));
    last_row  = CNT_W'(tile_row) >= (nr_c - CNT_W'(1));
    end_frame = end_row && last_row;
    h_cur     = tile_h(block_shape);
    row_h     = 12'(tile_row) * 12'(h_cur);
    col_cur   = block_shape[1] ? {tile_column, 2'b00} : {1'b0, tile_column, 1'b0};
    case (shape_t'(block_shape))
      SHAPE_2X2: base_cur = RA_W'({block_pointer, 2'b00});
      SHAPE_2X3: base_cur = RA_W'({block_pointer, 2'b00}) + RA_W'({block_pointer, 1'b0});
      SHAPE_4X2: base_cur = RA_W'({block_pointer, 3'b000});
      SHAPE_4X4: base_cur = RA_W'({block_pointer, 4'b0000});
      default:   base_cur = RA_W'({block_pointer, 2'b00});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_column <= '0;
      tile_row    <= '0;
    end else if (dec_accept) begin
      if (end_row) begin
        tile_column <= '0;
        tile_row    <= last_row ? '0 : tile_row + POS_W'(1);
      end else begin
        tile_column <= tile_column + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (dec_accept) begin
      busy <= 1'b1;
    end else if (issue && gen_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_accept) begin
      gen_base      <= base_cur;
      gen_n         <= '0;
      gen_x         <= '0;
      gen_wm1       <= tile_wm1(block_shape);
      gen_szm1      <= tile_szm1(block_shape);
      gen_line      <= PADDR_W'(25'(row_h) * 25'(buffer_width));
      gen_col       <= col_cur;
      gen_bw        <= buffer_width;
      gen_end_frame <= end_frame;
    end else if (issue) begin
      gen_n <= gen_n + 4'd1;
      if (gen_x == gen_wm1) begin
        gen_x    <= '0;
        gen_line <= gen_line + PADDR_W'(gen_bw);
      end else begin
        gen_x <= gen_x + 2'd1;
      end
    end
  end

  // store: write on codebook beats, read one pixel per issued slot
  logic [RA_W-1:0] rd_addr;
  assign rd_addr = gen_base + RA_W'(gen_n);

  always_ff @(posedge clk) begin
    if (wr_accept && (32'(codebook_address) < CB_BYTES))
      store[CB_AW'(codebook_address)] <= codebook_byte;
    if (issue)
      rd_data <= store[CB_AW'(rd_addr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_addr       <= gen_line + PADDR_W'(gen_col) + PADDR_W'(gen_x);
      s1_oob        <= !(32'(rd_addr) < CB_BYTES);
      s1_last_tile  <= gen_last;
      s1_last_frame <= gen_last && gen_end_frame;
    end
  end

  assign pixel_valid   = s1_valid;
  assign pixel_address = s1_addr;
  assign pixel_value   = s1_oob ? 8'd0 : rd_data;
  assign last_of_tile  = s1_last_tile;
  assign last_of_frame = s1_last_frame;

endmodule
`default_nettype wire

/* sim/vq_block_decoder_test.sv */
// ----------------------------------------------------------------------------
// vq_block_decoder_test
// Self-checking bench for the VQ tile decoder. Codebook beats and pointer
// beats go in under random gaps and output stalls. A scoreboard keeps its own
// copy of the store, the registers and the tile position. It expands each
// accepted pointer into the expected pixels and checks every output beat
// against them in order.
// ----------------------------------------------------------------------------
module vq_block_decoder_test;
  import vqbd_pkg::*;

  localparam int  CLK_PERIOD     = 10;
  localparam int  HOLD_CYCLES    = 400;
  localparam int  WATCHDOG_LIMIT = 5000;
  localparam int  TAIL_CYCLES    = 20;
  localparam int  NUM_PHASES     = 9;
  localparam int  PHASE_BEATS    = 50;
  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_DECODE   = 1'b1;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  cfg_index_t          cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                item_valid;
  logic                item_stall;
  logic                mode;
  logic [11:0]         codebook_address;
  logic [7:0]          codebook_byte;
  logic [7:0]          block_pointer;
  logic                pixel_valid;
  logic                pixel_stall;
  logic [PADDR_W-1:0]  pixel_address;
  logic [7:0]          pixel_value;
  logic                last_of_tile;
  logic                last_of_frame;

  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int hold_reqs     = 0;
  int quiet_cycles  = 0;
  int sent_beats    = 0;
  bit cb_loaded [CB_BYTES];

  typedef struct packed {
    logic [PADDR_W-1:0] addr;
    logic [7:0]         value;
    logic               last_tile;
    logic               last_frame;
  } pixel_t;

  class vq_tile_scoreboard;
    logic [7:0]  cb_copy [CB_BYTES];
    logic [1:0]  shape;
    logic [10:0] row_tiles;
    logic [10:0] frame_rows;
    logic [12:0] stride;
    logic [9:0]  col;
    logic [9:0]  row;
    pixel_t      tile_q [$];
    int          errors;

    function new();
      shape      = SHAPE_4X2;
      row_tiles  = 11'd80;
      frame_rows = 11'd100;
      stride     = 13'd320;
      col        = '0;
      row        = '0;
      errors     = 0;
      foreach (cb_copy[i]) cb_copy[i] = '0;
    endfunction

    function int unsigned tile_width();
      case (shape_t'(shape))
        SHAPE_4X2, SHAPE_4X4: return 4;
        default:              return 2;
      endcase
    endfunction

    function int unsigned tile_height();
      case (shape_t'(shape))
        SHAPE_2X3: return 3;
        SHAPE_4X4: return 4;
        default:   return 2;
      endcase
    endfunction

    function int unsigned entry_size();
      return tile_width() * tile_height();
    endfunction

    function int unsigned clamp_tiles(logic [10:0] v);
      if (v == '0) return 1;
      if (v > MAX_CNT) return MAX_CNT;
      return v;
    endfunction

    function int pending();
      return tile_q.size();
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_BLOCK_SHAPE:    shape      = d[1:0];
        CFG_BLOCKS_PER_ROW: row_tiles  = d[10:0];
        CFG_NUM_ROWS:       frame_rows = d[10:0];
        CFG_BUFFER_WIDTH:   stride     = d[12:0];
        default: ;
      endcase
    endfunction

    // store update, or expansion of one pointer into its tile of pixels
    function void note_item(logic m, logic [11:0] a, logic [7:0] b, logic [7:0] p);
      int unsigned     w, h, sz, tx, ty, base, ra, n, bpr, nr;
      longint unsigned line, addr;
      bit              row_end, frame_end;
      pixel_t          px;
      if (m == MODE_WRITE) begin
        if (a < CB_BYTES) cb_copy[a] = b;
        return;
      end
      w    = tile_width();
      h    = tile_height();
      sz   = w * h;
      bpr  = clamp_tiles(row_tiles);
      nr   = clamp_tiles(frame_rows);
      base = p * sz;
      // a position at or past the clamped count counts as the last one
      row_end   = (col >= bpr - 1);
      frame_end = row_end && (row >= nr - 1);
      n = 0;
      for (ty = 0; ty < h; ty++) begin
        for (tx = 0; tx < w; tx++) begin
          ra   = base + n;
          line = row * h + ty;
          addr = line * stride + col * w + tx;
          px.addr       = addr[PADDR_W-1:0];
          px.value      = (ra < CB_BYTES) ? cb_copy[ra] : 8'h00;
          px.last_tile  = (n == sz - 1);
          px.last_frame = px.last_tile && frame_end;
          tile_q.push_back(px);
          n++;
        end
      end
      if (row_end) begin
        col = '0;
        if (row >= nr - 1) row = '0;
        else row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_pixel(logic [PADDR_W-1:0] a, logic [7:0] v, logic lt, logic lf);
      pixel_t want;
      if (tile_q.size() == 0) begin
        report($sformatf("pixel beat with none pending, address %h", a));
        return;
      end
      want = tile_q.pop_front();
      if (a !== want.addr)
        report($sformatf("pixel_address %h, want %h", a, want.addr));
      if (v !== want.value)
        report($sformatf("pixel_value %h, want %h at %h", v, want.value, want.addr));
      if (lt !== want.last_tile)
        report($sformatf("last_of_tile %b, want %b at %h", lt, want.last_tile, want.addr));
      if (lf !== want.last_frame)
        report($sformatf("last_of_frame %b, want %b at %h", lf, want.last_frame, want.addr));
    endtask
  endclass

  vq_tile_scoreboard sb = new();

  vq_block_decoder u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .mode             (mode),
    .codebook_address (codebook_address),
    .codebook_byte    (codebook_byte),
    .block_pointer    (block_pointer),
    .pixel_valid      (pixel_valid),
    .pixel_stall      (pixel_stall),
    .pixel_address    (pixel_address),
    .pixel_value      (pixel_value),
    .last_of_tile     (last_of_tile),
    .last_of_frame    (last_of_frame)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // beat monitor: everything sampled here is the pre-edge value
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.set_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall)
        sb.note_item(mode, codebook_address, codebook_byte, block_pointer);
      if (pixel_valid && !pixel_stall)
        sb.check_pixel(pixel_address, pixel_value, last_of_tile, last_of_frame);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (pixel_valid && !pixel_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // output side: random stall, or a long hold when one is requested
  initial begin : rx_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    pixel_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel_stall <= 1'b1;
      end else begin
        pixel_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  task automatic send_beat(input logic m, input logic [11:0] a, input logic [7:0] b,
                           input logic [7:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid       <= 1'b1;
    mode             <= m;
    codebook_address <= a;
    codebook_byte    <= b;
    block_pointer    <= p;
    do @(posedge clk); while (item_stall);
    sent_beats++;
  endtask

  task automatic send_write(input logic [11:0] a, input logic [7:0] b);
    send_beat(MODE_WRITE, a, b, 8'($urandom));
    cb_loaded[a] = 1'b1;
  endtask

  task automatic send_pointer(input logic [7:0] p);
    send_beat(MODE_DECODE, 12'($urandom), 8'($urandom), p);
  endtask

  function automatic bit entry_loaded(input logic [7:0] p, input int unsigned sz);
    int unsigned i;
    for (i = 0; i < sz; i++)
      if (!cb_loaded[p * sz + i]) return 1'b0;
    return 1'b1;
  endfunction

  // writes the missing bytes of an entry, or all of them on refresh
  task automatic load_entry(input logic [7:0] p, input int unsigned sz, input bit refresh);
    int unsigned i;
    int unsigned ra;
    for (i = 0; i < sz; i++) begin
      ra = p * sz + i;
      if (refresh || !cb_loaded[ra]) send_write(12'(ra), 8'($urandom));
    end
  endtask

  task automatic random_step(input int fresh_pct);
    int unsigned sz;
    int unsigned tries;
    logic [7:0]  p;
    if ($urandom_range(99) < 15) begin
      send_write(12'($urandom), 8'($urandom));
      return;
    end
    sz = sb.entry_size();
    p  = 8'($urandom);
    if ($urandom_range(99) >= fresh_pct)
      for (tries = 0; tries < 16 && !entry_loaded(p, sz); tries++) p = 8'($urandom);
    load_entry(p, sz, $urandom_range(99) < 10);
    send_pointer(p);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] b,
                              input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] w);
    write_reg(CFG_BLOCK_SHAPE, s);
    write_reg(CFG_BLOCKS_PER_ROW, b);
    write_reg(CFG_NUM_ROWS, n);
    write_reg(CFG_BUFFER_WIDTH, w);
    cfg_write <= 1'b0;
  endtask

  // reset shape is 4x2: entry 0 is bytes 0..7, entry 255 is bytes 2040..2047
  task automatic directed_beats();
    logic [7:0] pattern [8];
    int unsigned i;
    pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
    for (i = 0; i < 8; i++) send_write(12'(i), pattern[i]);
    send_write(12'hFFF, 8'hFF);
    send_pointer(8'h00);
    for (i = 0; i < 8; i++) send_write(12'(2040 + i), ~pattern[i]);
    send_pointer(8'hFF);
    // overwrite a byte of entry 0 right before decoding it again
    send_write(12'h000, 8'h3C);
    send_pointer(8'h00);
    send_pointer(8'hFF);
  endtask

  initial begin : stimulus
    int ph;
    int i;
    int beat_mark;
    int fresh;
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= CFG_BLOCK_SHAPE;
    cfg_data         <= '0;
    item_valid       <= 1'b0;
    mode             <= MODE_WRITE;
    codebook_address <= '0;
    codebook_byte    <= '0;
    block_pointer    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_beats();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        1: program_regs(CFG_W'(SHAPE_2X2), 13'd1, 13'd1, 13'd1);
        2: program_regs(CFG_W'(SHAPE_2X3), 13'd3, 13'd2, 13'd4096);
        3: program_regs(CFG_W'(SHAPE_4X4), 13'd0, 13'd0, 13'd0);
        4: program_regs(CFG_W'(SHAPE_4X2), 13'd1024, 13'd1024, 13'd8191);
        5: program_regs(CFG_W'(SHAPE_2X3), 13'd2047, 13'd2047, 13'd17);
        // one tile per row down a deep frame with the widest stride
        6: program_regs(CFG_W'(SHAPE_4X4), 13'd1, 13'd1024, 13'd8191);
        7: program_regs(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(1, 12)),
                        CFG_W'($urandom_range(1, 4)), CFG_W'($urandom));
        8: program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                        CFG_W'($urandom));
        default: ;
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 62; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 62; end
        default: begin send_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      fresh     = (ph == 6) ? 5 : 30;
      beat_mark = sent_beats + PHASE_BEATS;
      for (i = 0; sent_beats < beat_mark; i++) begin
        random_step(fresh);
        if (ph == 2 && i == 1) hold_reqs++;
        if (ph == 4 && i == 2) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d pixels never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* vq_block_decoder.f */
design/vqbd_pkg.sv
design/vq_block_decoder.sv
sim/vq_block_decoder_test.sv
